// ===== rtl/core/unsharp_mask_3x3_defines.svh =====
// Assertion macros for the unsharp mask block.
`ifndef UNSHARP_MASK_3X3_DEFINES_SVH
`define UNSHARP_MASK_3X3_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define UMASK_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define UMASK_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`endif

// ===== rtl/core/umask_pkg.sv =====
// Shared types, constants and helpers for the unsharp mask block.
`timescale 1ns / 1ps

package umask_pkg;

   localparam int unsigned MAX_SIZE_DEF  = 512;
   localparam int unsigned SIZE_CFG_MAX  = 1023;
   localparam int unsigned PIX_W         = 8;
   localparam int unsigned GAIN_W        = 10;
   localparam int unsigned CSR_DATA_W    = 10;
   localparam int unsigned CSR_IDX_W     = 2;
   localparam int unsigned BLUR_W        = 12;
   localparam int unsigned QUEUE_DEPTH   = 2;

   localparam logic [CSR_DATA_W-1:0] SIZE_RST   = 10'd512;
   localparam logic [GAIN_W-1:0]     GAIN_A_RST = 10'd448;
   localparam logic [GAIN_W-1:0]     GAIN_B_RST = 10'd192;

   localparam logic [1:0] TAP_WEIGHT [3] = '{2'd1, 2'd2, 2'd1};

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_IMAGE_SIZE = 2'd0,
      REG_GAIN_A     = 2'd1,
      REG_GAIN_B     = 2'd2
   } csr_reg_type;

   typedef struct packed {
      logic [PIX_W-1:0]  center;
      logic [BLUR_W-1:0] blur;
      logic              last;
   } q_word_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   typedef struct packed {
      logic busy;
      logic frame_start;
   } front_stat_type;

   function automatic int unsigned size_limit(int unsigned max_size);
      return (max_size < SIZE_CFG_MAX) ? max_size : SIZE_CFG_MAX;
   endfunction

endpackage

// ===== rtl/core/umask_req_if.sv =====
// Input channel: pixel and flush words.
`timescale 1ns / 1ps

interface umask_req_if
   import umask_pkg::*;
();
   logic             valid;
   logic             ready;
   logic             kind;
   logic [PIX_W-1:0] pixel;

   modport source (output valid, kind, pixel, input ready);
   modport sink   (input valid, kind, pixel, output ready);
endinterface

// ===== rtl/core/umask_rsp_if.sv =====
// Result channel: sharpened pixel words.
`timescale 1ns / 1ps

interface umask_rsp_if
   import umask_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] out_pixel;
   logic             frame_last;

   modport source (output valid, out_pixel, frame_last, input ready);
   modport sink   (input valid, out_pixel, frame_last, output ready);
endinterface

// ===== rtl/core/unsharp_mask_3x3.sv =====
// Path: a result passes the front-end stage, queue, product and output registers to rsp.
// Throughput: one word per cycle unless rsp stalls; the window front end and the multiply
// back end each take one word a cycle and a two-entry queue lets either side stall alone.
// Reset: synchronous; registers go to their defaults, frame position and window clear.
// Line stores are not cleared, so there is no clearing pass and words are taken at once.
`timescale 1ns / 1ps
`include "unsharp_mask_3x3_defines.svh"

module unsharp_mask_3x3
   import umask_pkg::*;
#(
   parameter int unsigned MAX_SIZE = MAX_SIZE_DEF
)(
   input  logic                  clock,
   input  logic                  reset,
   umask_req_if.sink             req,
   umask_rsp_if.source           rsp,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);
   localparam int unsigned SMAX = size_limit(MAX_SIZE);
   localparam int unsigned S_W  = $clog2(SMAX + 1);
   localparam logic [S_W-1:0] SIZE_RST_EFF =
      (int'(SIZE_RST) > SMAX) ? S_W'(SMAX) : S_W'(SIZE_RST);

   logic [S_W-1:0]    size_ff, size_in;
   logic [GAIN_W-1:0] gain_a_ff, gain_a_in;
   logic [GAIN_W-1:0] gain_b_ff, gain_b_in;
   logic              restart;
   logic              size_write;

   logic           q_push, q_pop;
   q_word_type     q_in_word, q_out_word;
   q_stat_type     q_stat;
   front_stat_type front_stat;

   assign size_write = csr_we && (csr_index == REG_IMAGE_SIZE);

   always_comb begin
      size_in   = size_ff;
      gain_a_in = gain_a_ff;
      gain_b_in = gain_b_ff;
      restart   = 1'b0;
      if (csr_we) begin
         case (csr_index)
            REG_IMAGE_SIZE: begin
               restart = 1'b1;
               if (csr_wdata == '0) begin
                  size_in = S_W'(1);
               end else if (csr_wdata > CSR_DATA_W'(SMAX)) begin
                  size_in = S_W'(SMAX);
               end else begin
                  size_in = csr_wdata[S_W-1:0];
               end
            end
            REG_GAIN_A: begin
               gain_a_in = csr_wdata[GAIN_W-1:0];
            end
            REG_GAIN_B: begin
               gain_b_in = csr_wdata[GAIN_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff   <= SIZE_RST_EFF;
         gain_a_ff <= GAIN_A_RST;
         gain_b_ff <= GAIN_B_RST;
      end else begin
         size_ff   <= size_in;
         gain_a_ff <= gain_a_in;
         gain_b_ff <= gain_b_in;
      end
   end

   umask_front #(
      .MAX_SIZE (MAX_SIZE)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .size      (size_ff),
      .restart   (restart),
      .push      (q_push),
      .push_word (q_in_word),
      .q_stat    (q_stat),
      .stat      (front_stat)
   );

   umask_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_word (q_in_word),
      .pop       (q_pop),
      .pop_word  (q_out_word),
      .stat      (q_stat)
   );

   umask_back u_back (
      .clock  (clock),
      .reset  (reset),
      .q_word (q_out_word),
      .q_stat (q_stat),
      .pop    (q_pop),
      .gain_a (gain_a_ff),
      .gain_b (gain_b_ff),
      .rsp    (rsp)
   );

   `UMASK_NEVER(a_queue_overflow, q_push && q_stat.full, "word pushed into a full queue")
   `UMASK_NEVER(a_queue_underflow, q_pop && q_stat.empty, "word popped from an empty queue")
   `UMASK_NEVER(a_front_ready, !front_stat.busy && !req.ready, "idle front end not ready")
   `UMASK_ASSERT(a_size_restart, size_write |=> front_stat.frame_start, "no restart on size")

endmodule

// ===== rtl/core/umask_queue.sv =====
// Short word queue between the window front end and the arithmetic back end.
`timescale 1ns / 1ps

module umask_queue
   import umask_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  q_word_type push_word,
   input  logic       pop,
   output q_word_type pop_word,
   output q_stat_type stat
);
   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   q_word_type       entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

   assign pop_word   = entry_ff[rd_ptr_ff];
   assign stat.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);

endmodule

// ===== rtl/core/umask_front.sv =====
// Front end: frame position, line stores, 3x3 window, border select and blur sum.
`timescale 1ns / 1ps

module umask_front
   import umask_pkg::*;
#(
   parameter int unsigned MAX_SIZE = MAX_SIZE_DEF
)(
   input  logic                clock,
   input  logic                reset,
   umask_req_if.sink           req,
   input  logic [$clog2(size_limit(MAX_SIZE) + 1)-1:0] size,
   input  logic                restart,
   output logic                push,
   output q_word_type          push_word,
   input  q_stat_type          q_stat,
   output front_stat_type      stat
);
   localparam int unsigned SMAX  = size_limit(MAX_SIZE);
   localparam int unsigned COL_W = $clog2(SMAX);
   localparam int unsigned S_W   = $clog2(SMAX + 1);
   localparam int unsigned ROW_W = $clog2(SMAX + 2);

   logic [COL_W-1:0] in_col_ff, in_col_in;
   logic [ROW_W-1:0] in_row_ff, in_row_in;
   logic [COL_W-1:0] out_col_ff, out_col_in;
   logic [COL_W-1:0] out_row_ff, out_row_in;

   logic             f1_valid_ff, f1_valid_in;
   logic [PIX_W-1:0] f1_pix_ff;
   logic [COL_W-1:0] f1_col_ff;
   logic             f1_emit_ff;
   logic             f1_last_ff;
   logic             f1_top_ff, f1_bot_ff, f1_left_ff, f1_right_ff;

   logic [PIX_W-1:0] line_a [SMAX];
   logic [PIX_W-1:0] line_b [SMAX];
   logic [PIX_W-1:0] rd_a_ff, rd_b_ff;

   logic [PIX_W-1:0] win_ff [3][3];
   logic [PIX_W-1:0] win_in [3][3];
   logic [PIX_W-1:0] sel    [3][3];

   logic              accept;
   logic              f1_adv;
   logic [ROW_W-1:0]  s_row;
   logic              pix_phase;
   logic [PIX_W-1:0]  pix_in;
   logic              emit_in, last_in;
   logic              col_wrap, out_col_wrap;
   logic              top_in, bot_in, left_in, right_in;
   logic [BLUR_W-1:0] blur;

   assign f1_adv    = f1_valid_ff && (!f1_emit_ff || !q_stat.full);
   assign req.ready = !f1_valid_ff || f1_adv;
   assign accept    = req.valid && req.ready;

   always_comb begin
      s_row        = ROW_W'(size);
      pix_phase    = in_row_ff < s_row;
      pix_in       = (pix_phase && !req.kind) ? req.pixel : '0;
      emit_in      = (in_row_ff > ROW_W'(1)) || ((in_row_ff == ROW_W'(1)) && (in_col_ff != '0));
      last_in      = (in_row_ff == s_row + ROW_W'(1));
      col_wrap     = (S_W'(in_col_ff) == size - S_W'(1));
      out_col_wrap = (S_W'(out_col_ff) == size - S_W'(1));
      top_in       = (out_row_ff == '0);
      bot_in       = (S_W'(out_row_ff) == size - S_W'(1));
      left_in      = (out_col_ff == '0);
      right_in     = out_col_wrap;
   end

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (accept) begin
         if (col_wrap) begin
            in_col_in = '0;
            in_row_in = in_row_ff + ROW_W'(1);
         end else begin
            in_col_in = in_col_ff + COL_W'(1);
         end
         if (emit_in) begin
            if (out_col_wrap) begin
               out_col_in = '0;
               out_row_in = out_row_ff + COL_W'(1);
            end else begin
               out_col_in = out_col_ff + COL_W'(1);
            end
         end
         if (last_in) begin
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
         end
      end
      if (restart) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end
   end

   always_comb begin
      f1_valid_in = f1_valid_ff;
      if (accept) begin
         f1_valid_in = 1'b1;
      end else if (f1_adv) begin
         f1_valid_in = 1'b0;
      end
      if (restart) begin
         f1_valid_in = 1'b0;
      end
   end

   always_comb begin
      logic [1:0] r_idx [3];
      logic [1:0] c_idx [3];
      for (int r = 0; r < 3; r++) begin
         win_in[r][0] = win_ff[r][1];
         win_in[r][1] = win_ff[r][2];
      end
      win_in[0][2] = rd_b_ff;
      win_in[1][2] = rd_a_ff;
      win_in[2][2] = f1_pix_ff;
      r_idx[0] = f1_top_ff   ? 2'd1 : 2'd0;
      r_idx[1] = 2'd1;
      r_idx[2] = f1_bot_ff   ? 2'd1 : 2'd2;
      c_idx[0] = f1_left_ff  ? 2'd1 : 2'd0;
      c_idx[1] = 2'd1;
      c_idx[2] = f1_right_ff ? 2'd1 : 2'd2;
      blur = '0;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            sel[r][c] = win_in[r_idx[r]][c_idx[c]];
            blur = blur + BLUR_W'(TAP_WEIGHT[r]) * BLUR_W'(TAP_WEIGHT[c]) * BLUR_W'(sel[r][c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         f1_valid_ff <= 1'b0;
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else begin
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         f1_valid_ff <= f1_valid_in;
         if (restart) begin
            for (int r = 0; r < 3; r++) begin
               for (int c = 0; c < 3; c++) begin
                  win_ff[r][c] <= '0;
               end
            end
         end else if (f1_adv) begin
            win_ff <= win_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         f1_pix_ff   <= pix_in;
         f1_col_ff   <= in_col_ff;
         f1_emit_ff  <= emit_in;
         f1_last_ff  <= last_in;
         f1_top_ff   <= top_in;
         f1_bot_ff   <= bot_in;
         f1_left_ff  <= left_in;
         f1_right_ff <= right_in;
      end
   end

   always_ff @(posedge clock) begin
      if (f1_adv) begin
         line_a[f1_col_ff] <= f1_pix_ff;
         line_b[f1_col_ff] <= rd_a_ff;
      end
      if (accept) begin
         if (f1_adv && (f1_col_ff == in_col_ff)) begin
            rd_a_ff <= f1_pix_ff;
            rd_b_ff <= rd_a_ff;
         end else begin
            rd_a_ff <= line_a[in_col_ff];
            rd_b_ff <= line_b[in_col_ff];
         end
      end
   end

   assign push             = f1_adv && f1_emit_ff;
   assign push_word.center = win_in[1][1];
   assign push_word.blur   = blur;
   assign push_word.last   = f1_last_ff;

   assign stat.busy        = f1_valid_ff;
   assign stat.frame_start = (in_col_ff == '0) && (in_row_ff == '0) &&
                             (out_col_ff == '0) && (out_row_ff == '0);

endmodule

// ===== rtl/core/umask_back.sv =====
// Back end: gain products, difference, scale and clamp, output register.
`timescale 1ns / 1ps

module umask_back
   import umask_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  q_word_type        q_word,
   input  q_stat_type        q_stat,
   output logic              pop,
   input  logic [GAIN_W-1:0] gain_a,
   input  logic [GAIN_W-1:0] gain_b,
   umask_rsp_if.source       rsp
);
   localparam int unsigned PA_W   = GAIN_W + PIX_W;
   localparam int unsigned PB_W   = GAIN_W + BLUR_W;
   localparam int unsigned DIFF_W = PB_W + 1;

   logic             b1_valid_ff, b1_valid_in;
   logic [PA_W-1:0]  prod_a_ff, prod_a_in;
   logic [PB_W-1:0]  prod_b_ff, prod_b_in;
   logic             b1_last_ff;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0] rsp_pix_ff, rsp_pix_in;
   logic             rsp_last_ff;

   logic              out_free;
   logic              b1_free;
   logic signed [DIFF_W-1:0] diff;

   function automatic logic [PB_W-1:0] prod_a_in_scaled(logic [PA_W-1:0] p);
      return {p, 4'b0000};
   endfunction

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign b1_free  = !b1_valid_ff || out_free;
   assign pop      = !q_stat.empty && b1_free;

   always_comb begin
      prod_a_in = PA_W'(gain_a) * PA_W'(q_word.center);
      prod_b_in = PB_W'(gain_b) * PB_W'(q_word.blur);
      diff = $signed({1'b0, prod_a_in_scaled(prod_a_ff)}) - $signed({1'b0, prod_b_ff});
      if (diff[DIFF_W-1]) begin
         rsp_pix_in = '0;
      end else if (diff[DIFF_W-2:12] > (DIFF_W-13)'(255)) begin
         rsp_pix_in = '1;
      end else begin
         rsp_pix_in = diff[PIX_W+11:12];
      end
      b1_valid_in  = b1_free ? pop : b1_valid_ff;
      rsp_valid_in = out_free ? b1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         b1_valid_ff  <= b1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         prod_a_ff  <= prod_a_in;
         prod_b_ff  <= prod_b_in;
         b1_last_ff <= q_word.last;
      end
      if (out_free && b1_valid_ff) begin
         rsp_pix_ff  <= rsp_pix_in;
         rsp_last_ff <= b1_last_ff;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.out_pixel  = rsp_pix_ff;
   assign rsp.frame_last = rsp_last_ff;

endmodule
